FILE: rtl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
// No dependencies; used by the channel interfaces, the cell and the top level.
package spq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int PRIORITY_WIDTH = 8;
    localparam int TAG_WIDTH      = 16;
    localparam int COUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic [PRIORITY_WIDTH-1:0] priority_req;
        logic [TAG_WIDTH-1:0]      exam_tag;
    } req_t;

    typedef struct packed {
        logic [TAG_WIDTH-1:0]      out_tag;
        logic [PRIORITY_WIDTH-1:0] out_priority;
        status_t                   status;
        logic                      is_empty;
        logic [COUNT_WIDTH-1:0]    entry_count;
    } rsp_t;

    typedef struct packed {
        logic [PRIORITY_WIDTH-1:0] prio;
        logic [TAG_WIDTH-1:0]      tag;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   ins;
        logic   rem;
        entry_t item;
    } cell_op_t;

endpackage

FILE: rtl/spq_req_if.sv
// Request channel: valid/ready handshake carrying one queue command.
// Depends on spq_pkg.
interface spq_req_if;
    logic          valid;
    logic          ready;
    spq_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/spq_rsp_if.sv
// Response channel: valid/ready handshake carrying one queue result.
// Depends on spq_pkg.
interface spq_rsp_if;
    logic          valid;
    logic          ready;
    spq_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with an incoming
// insert and shifts with its neighbours. Depends on spq_pkg.
module spq_cell (
    input  logic              clk,
    input  spq_pkg::cell_op_t op,
    input  logic              occupied,
    input  spq_pkg::entry_t   left,
    input  logic              left_behind,
    input  spq_pkg::entry_t   right,
    output spq_pkg::entry_t   entry,
    output logic              behind
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // new entry stays behind this one on equal priority
    assign behind = occupied && (entry_reg.prio >= op.item.prio);
    assign entry  = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.ins)
        begin
            if (!behind)
            begin
                entry_next = left_behind ? op.item : left;
            end
        end
        else if (op.rem)
        begin
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: rtl/stable_priority_queue_top.sv
// A request's response is loaded into the output register at the same edge that accepts
// the request. Throughput: one request per cycle while responses are taken; every cell
// compares and shifts at once. A new request is taken only at an edge where the output
// register is empty or its response leaves; a response held by the receiver stalls requests.
// Reset clears the fill count and the output valid; the cell storage is not reset.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_cell.
module stable_priority_queue_top (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req_ch,
    spq_rsp_if.source rsp_ch
);

    localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
    localparam int CW    = spq_pkg::COUNT_WIDTH;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    spq_pkg::rsp_t     rsp_data_reg;
    spq_pkg::rsp_t     rsp_data_next;

    logic              fire;
    logic              full;
    logic              empty;
    spq_pkg::cell_op_t op;

    spq_pkg::entry_t   cell_entry [DEPTH];
    logic [DEPTH-1:0]  behind;
    logic [DEPTH-1:0]  occupied;

    assign req_ch.ready = !rsp_valid_reg || rsp_ch.ready;
    assign fire         = req_ch.valid && req_ch.ready;
    assign full         = (count_reg == CW'(DEPTH));
    assign empty        = (count_reg == '0);

    assign rsp_ch.valid = rsp_valid_reg;
    assign rsp_ch.data  = rsp_data_reg;

    always_comb
    begin
        op.ins           = fire && (req_ch.data.cmd == spq_pkg::CMD_INSERT) && !full;
        op.rem           = fire && (req_ch.data.cmd == spq_pkg::CMD_REMOVE) && !empty;
        op.item.prio     = req_ch.data.priority_req;
        op.item.tag      = req_ch.data.exam_tag;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            spq_pkg::entry_t left_entry;
            spq_pkg::entry_t right_entry;
            logic            left_beh;

            assign occupied[gi] = (CW'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_entry = cell_entry[0];
                assign left_beh   = 1'b1;
            end
            else
            begin : g_body
                assign left_entry = cell_entry[gi-1];
                assign left_beh   = behind[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_entry = cell_entry[gi];
            end
            else
            begin : g_mid
                assign right_entry = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .op          (op),
                .occupied    (occupied[gi]),
                .left        (left_entry),
                .left_behind (left_beh),
                .right       (right_entry),
                .entry       (cell_entry[gi]),
                .behind      (behind[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (op.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.rem)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_ch.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end

        rsp_data_next              = rsp_data_reg;
        if (fire)
        begin
            rsp_data_next.out_tag      = '0;
            rsp_data_next.out_priority = '0;
            rsp_data_next.status       = spq_pkg::STATUS_OK;
            if (req_ch.data.cmd == spq_pkg::CMD_INSERT)
            begin
                if (full)
                begin
                    rsp_data_next.status = spq_pkg::STATUS_FULL;
                end
            end
            else if (empty)
            begin
                rsp_data_next.status = spq_pkg::STATUS_EMPTY;
            end
            else
            begin
                rsp_data_next.out_tag      = cell_entry[0].tag;
                rsp_data_next.out_priority = cell_entry[0].prio;
            end
            rsp_data_next.is_empty    = (count_next == '0);
            rsp_data_next.entry_count = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        op.ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the queue");

    a_sorted_front: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CW'(2) |-> cell_entry[0].prio >= cell_entry[1].prio)
        else $error("front entries out of order");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_data_reg.is_empty == (rsp_data_reg.entry_count == '0))
        else $error("empty flag disagrees with count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_data_reg.status == spq_pkg::STATUS_FULL
            |-> rsp_data_reg.entry_count == CW'(DEPTH))
        else $error("full status on a queue with room");

endmodule
